@@ design/fkx_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow key extractor package
// Shared constants, widths, the queued packet record and protocol decoding.
// ----------------------------------------------------------------------------
package fkx_pkg;

    localparam int unsigned FKX_QUEUE_DEPTH = 2;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 112;
    localparam int unsigned M_TUSER_W = 2;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [0:0] REG_FRAG_CHECK_EN = 1'b0;

    localparam logic [7:0] PROTO_NONE    = 8'd0;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_DCCP    = 8'd33;
    localparam logic [7:0] PROTO_ESP     = 8'd50;
    localparam logic [7:0] PROTO_AH      = 8'd51;
    localparam logic [7:0] PROTO_SCTP    = 8'd132;
    localparam logic [7:0] PROTO_UDPLITE = 8'd136;

    localparam logic [5:0] FRAG_HI_MASK = 6'h3F;
    localparam logic [6:0] MIN_HEADER   = 7'd20;
    localparam logic [6:0] COUNT_MAX    = 7'd127;

    localparam logic [6:0] IDX_HEADER_LEN = 7'd0;
    localparam logic [6:0] IDX_FRAG_HI    = 7'd6;
    localparam logic [6:0] IDX_FRAG_LO    = 7'd7;
    localparam logic [6:0] IDX_PROTOCOL   = 7'd9;
    localparam logic [6:0] IDX_SRC_FIRST  = 7'd12;
    localparam logic [6:0] IDX_DST_FIRST  = 7'd16;
    localparam logic [6:0] IDX_DST_END    = 7'd20;
    localparam logic [6:0] WORD_BYTES     = 7'd4;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_FRAGMENT = 2'd1,
        ST_ERROR    = 2'd2
    } status_t;

    typedef struct packed {
        logic [6:0]  len;
        logic        ipv4;
        logic        frag;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] ports;
        logic [31:0] spi;
    } fkx_rec_t;

    typedef struct packed {
        logic has_port;
        logic is_ah;
    } port_kind_t;

    function automatic port_kind_t port_kind(input logic [7:0] proto);
        port_kind_t k;
        k = '0;
        case (proto)
            PROTO_TCP, PROTO_UDP, PROTO_DCCP, PROTO_ESP, PROTO_SCTP, PROTO_UDPLITE:
            begin
                k.has_port = 1'b1;
            end
            PROTO_AH:
            begin
                k.has_port = 1'b1;
                k.is_ah    = 1'b1;
            end
            default:
            begin
                k = '0;
            end
        endcase
        return k;
    endfunction

endpackage

@@ design/fkx_front.sv @@
// ----------------------------------------------------------------------------
// Flow key extractor byte parser
// Takes one packet byte per beat, captures header fields and the port word,
// and pushes one packet record into the queue at the last byte.
// ----------------------------------------------------------------------------
module fkx_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fkx_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [fkx_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            s_tlast,
    input  logic                            q_ready,
    output logic                            push,
    output fkx_pkg::fkx_rec_t               push_rec
);
    import fkx_pkg::*;

    logic [6:0]  count_reg;
    logic [6:0]  count_next;
    logic [3:0]  ihl_reg;
    logic [3:0]  ihl_next;
    logic        frag_reg;
    logic        frag_next;
    logic [7:0]  proto_reg;
    logic [7:0]  proto_next;
    logic [31:0] src_reg;
    logic [31:0] src_next;
    logic [31:0] dst_reg;
    logic [31:0] dst_next;
    logic [31:0] ports_reg;
    logic [31:0] ports_next;
    logic [31:0] spi_reg;
    logic [31:0] spi_next;
    logic        ipv4_reg;
    logic        ipv4_next;

    logic        accept;
    logic        start;
    logic [6:0]  idx;
    logic [6:0]  port_start;
    logic [7:0]  data_byte;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign data_byte = s_tdata;

    always_comb
    begin
        start = s_tuser[0] || (count_reg == '0);
        idx   = start ? '0 : count_reg;

        ipv4_next = start ? s_tuser[1] : ipv4_reg;
        ihl_next  = (idx == IDX_HEADER_LEN) ? data_byte[3:0] : ihl_reg;
        port_start = {1'b0, ihl_next, 2'b00};

        frag_next = (start ? 1'b0 : frag_reg)
                  | ((idx == IDX_FRAG_HI) && ((data_byte[5:0] & FRAG_HI_MASK) != '0))
                  | ((idx == IDX_FRAG_LO) && (data_byte != '0));

        proto_next = (idx == IDX_PROTOCOL) ? data_byte : (start ? '0 : proto_reg);

        src_next = start ? '0 : src_reg;
        if ((idx >= IDX_SRC_FIRST) && (idx < IDX_DST_FIRST))
        begin
            src_next = {src_next[23:0], data_byte};
        end

        dst_next = start ? '0 : dst_reg;
        if ((idx >= IDX_DST_FIRST) && (idx < IDX_DST_END))
        begin
            dst_next = {dst_next[23:0], data_byte};
        end

        ports_next = start ? '0 : ports_reg;
        if ((idx >= port_start) && (idx < port_start + WORD_BYTES))
        begin
            ports_next = {ports_next[23:0], data_byte};
        end

        spi_next = start ? '0 : spi_reg;
        if ((idx >= port_start + WORD_BYTES) && (idx < port_start + WORD_BYTES + WORD_BYTES))
        begin
            spi_next = {spi_next[23:0], data_byte};
        end

        count_next = (idx != COUNT_MAX) ? idx + 7'd1 : COUNT_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= s_tlast ? '0 : count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ihl_reg   <= ihl_next;
            frag_reg  <= frag_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            ports_reg <= ports_next;
            spi_reg   <= spi_next;
            ipv4_reg  <= ipv4_next;
        end
    end

    assign push = accept && s_tlast;

    always_comb
    begin
        push_rec.len   = count_next;
        push_rec.ipv4  = ipv4_next;
        push_rec.frag  = frag_next;
        push_rec.proto = proto_next;
        push_rec.ihl   = ihl_next;
        push_rec.src   = src_next;
        push_rec.dst   = dst_next;
        push_rec.ports = ports_next;
        push_rec.spi   = spi_next;
    end

endmodule

@@ design/fkx_queue.sv @@
// ----------------------------------------------------------------------------
// Flow key extractor record queue
// Short first-in first-out queue of packet records between parser and
// classifier.
// ----------------------------------------------------------------------------
module fkx_queue
#(
    parameter int unsigned DEPTH = fkx_pkg::FKX_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fkx_pkg::fkx_rec_t  push_rec,
    output logic               ready,
    input  logic               pop,
    output logic               valid,
    output fkx_pkg::fkx_rec_t  head_rec
);
    import fkx_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fkx_rec_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign ready    = (count_reg != CNT_FULL);
    assign valid    = (count_reg != '0);
    assign head_rec = entry_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

@@ design/fkx_back.sv @@
// ----------------------------------------------------------------------------
// Flow key extractor classifier
// Decides the status of each packet record and drives the registered
// flow key output.
// ----------------------------------------------------------------------------
module fkx_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            frag_check_en,
    input  logic                            q_valid,
    input  fkx_pkg::fkx_rec_t               q_rec,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fkx_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fkx_pkg::M_TUSER_W-1:0]   m_tuser
);
    import fkx_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    status_t               status_reg;
    status_t               status_next;
    logic [M_TDATA_W-1:0]  key_reg;
    logic [M_TDATA_W-1:0]  key_next;

    port_kind_t  kind;
    logic [6:0]  offset;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [31:0] port;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb
    begin
        kind   = port_kind(q_rec.proto);
        offset = {1'b0, q_rec.ihl, 2'b00} + (kind.is_ah ? WORD_BYTES : 7'd0);
        src    = '0;
        dst    = '0;
        proto  = '0;
        port   = '0;
        status_next = ST_NORMAL;
        if (q_rec.ipv4)
        begin
            if (q_rec.len < MIN_HEADER)
            begin
                status_next = ST_ERROR;
            end
            else if (frag_check_en && q_rec.frag)
            begin
                status_next = ST_FRAGMENT;
            end
            else if (q_rec.proto == PROTO_NONE)
            begin
                status_next = ST_ERROR;
            end
            else if (kind.has_port && ({1'b0, q_rec.len} < {1'b0, offset} + 8'd4))
            begin
                status_next = ST_ERROR;
            end
            else
            begin
                src   = q_rec.src;
                dst   = q_rec.dst;
                proto = q_rec.proto;
                if (kind.has_port)
                begin
                    port = kind.is_ah ? q_rec.spi : q_rec.ports;
                end
            end
        end
        if ((status_next == ST_NORMAL) && q_rec.ipv4)
        begin
            key_next = {1'b0, offset, port, proto, dst, src};
        end
        else
        begin
            key_next = '0;
        end
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            key_reg    <= key_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = key_reg;
    assign m_tuser  = status_reg;

endmodule

@@ design/ipv4_flow_key_extractor.sv @@
// ----------------------------------------------------------------------------
// IPv4 flow key extractor
// Parses a byte stream that starts at the network header and reports one
// flow key with a status for each packet.
// ----------------------------------------------------------------------------
// Packet bytes enter on the slave stream, one byte per beat, with tlast on a
// packet's final byte and tuser carrying the start-of-packet and IPv4 flags.
// Each packet yields one beat on the master stream: the status in tuser and
// the addresses, protocol, port word and transport offset in tdata.
// The APB port holds the fragment check enable at byte address 0.
// The parser takes one byte per cycle while the queue has room; its counter
// compare and field capture are combinational, so a new packet can start right
// after a last byte. A packet's record is written into the queue when its last
// byte is accepted; the classifier then pops it into its output register once
// that register is empty or being taken by the master side.
// The queue holds QUEUE_DEPTH records, so while the master side stalls the
// parser keeps accepting bytes until the queue is full, then drops tready.
// Reset clears the byte counter, the queue and the output valid flag, and
// sets the fragment check enable; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv4_flow_key_extractor
#(
    parameter int unsigned QUEUE_DEPTH = fkx_pkg::FKX_QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: packet_byte
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fkx_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: first_byte, is_ipv4
    input  logic [fkx_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: source_address, destination_address, ip_protocol, port_word,
    // transport_offset, one zero pad bit
    output logic [fkx_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser: status
    output logic [fkx_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fkx_pkg::PADDR_W-1:0]     paddr,
    input  logic [fkx_pkg::PDATA_W-1:0]     pwdata,
    output logic [fkx_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import fkx_pkg::*;

    logic      frag_check_en_reg;
    logic      cfg_write;
    logic      reg_hit;
    logic      q_ready;
    logic      push;
    fkx_rec_t  push_rec;
    logic      q_pop;
    logic      q_valid;
    fkx_rec_t  head_rec;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2:2] == REG_FRAG_CHECK_EN);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? {{(PDATA_W-1){1'b0}}, frag_check_en_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_check_en_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            frag_check_en_reg <= pwdata[0];
        end
    end

    fkx_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .push     (push),
        .push_rec (push_rec)
    );

    fkx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_rec (head_rec)
    );

    fkx_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .frag_check_en (frag_check_en_reg),
        .q_valid       (q_valid),
        .q_rec         (head_rec),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    a_key_zero_unless_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_NORMAL)) |-> (m_tdata == '0))
        else $error("flow key not cleared for a fragment or error status");

    a_last_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> q_valid)
        else $error("packet record missing from the queue after a last byte");

    a_status_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("unused status code on the output");

endmodule

@@ verif/tb_ipv4_flow_key_extractor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 flow key extractor testbench
// Streams packet bytes into the extractor and checks every flow key against
// a byte-level model of the parser. Directed packets come first. Randomized
// IPv4 packets, non-IPv4 packets, truncated packets and junk follow, under
// several fragment check settings, with random source gaps, sink stalls and
// one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_ipv4_flow_key_extractor;
    import fkx_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned PHASE_BYTES     = 180;
    localparam logic [PADDR_W-1:0] ADDR_FRAG_CHECK_EN = {REG_FRAG_CHECK_EN, 2'b00};

    typedef struct packed {
        status_t     status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [31:0] port_word;
        logic [6:0]  transport_offset;
    } flow_key_t;

    class flow_key_scoreboard;
        bit          frag_check_en;
        int unsigned byte_count;
        logic [3:0]  header_length;
        bit          fragment_seen;
        logic [7:0]  protocol_number;
        logic [31:0] source_capture;
        logic [31:0] destination_capture;
        logic [31:0] ports_capture;
        logic [31:0] spi_capture;
        bit          ipv4_packet;
        flow_key_t   expected_keys[$];
        int          errors;
        int          keys_checked;

        function new();
            frag_check_en = 1'b1;
            errors = 0;
            keys_checked = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_count = 0;
            header_length = '0;
            fragment_seen = 1'b0;
            protocol_number = '0;
            source_capture = '0;
            destination_capture = '0;
            ports_capture = '0;
            spi_capture = '0;
            ipv4_packet = 1'b0;
        endfunction

        function void note_byte(logic [7:0] value, bit first_flag, bit last_flag,
                                bit ipv4_flag);
            int unsigned idx;
            int unsigned base;
            int unsigned offset;
            int          extra;
            flow_key_t   key;
            if (first_flag || byte_count == 0)
            begin
                clear_packet();
                ipv4_packet = ipv4_flag;
            end
            idx = byte_count;
            if (idx == 0)
                header_length = value[3:0];
            base = header_length * 4;
            if (idx == 6 && (value[5:0] & FRAG_HI_MASK) != 0)
                fragment_seen = 1'b1;
            if (idx == 7 && value != 0)
                fragment_seen = 1'b1;
            if (idx == 9)
                protocol_number = value;
            if (idx >= 12 && idx < 16)
                source_capture = {source_capture[23:0], value};
            if (idx >= 16 && idx < 20)
                destination_capture = {destination_capture[23:0], value};
            if (idx >= base && idx < base + 4)
                ports_capture = {ports_capture[23:0], value};
            if (idx >= base + 4 && idx < base + 8)
                spi_capture = {spi_capture[23:0], value};
            byte_count = (idx < COUNT_MAX) ? idx + 1 : COUNT_MAX;
            if (!last_flag)
                return;

            key = '0;
            if (ipv4_packet)
            begin
                if (byte_count < MIN_HEADER)
                    key.status = ST_ERROR;
                else if (frag_check_en && fragment_seen)
                    key.status = ST_FRAGMENT;
                else if (protocol_number == PROTO_NONE)
                    key.status = ST_ERROR;
                else
                begin
                    case (protocol_number)
                        PROTO_TCP, PROTO_UDP, PROTO_DCCP, PROTO_ESP, PROTO_SCTP,
                        PROTO_UDPLITE: extra = 0;
                        PROTO_AH:      extra = 4;
                        default:       extra = -1;
                    endcase
                    offset = base;
                    if (extra >= 0)
                        offset = offset + extra;
                    if (extra >= 0 && byte_count < offset + 4)
                        key.status = ST_ERROR;
                    else
                    begin
                        key.src_addr = source_capture;
                        key.dst_addr = destination_capture;
                        key.protocol = protocol_number;
                        if (extra == 4)
                            key.port_word = spi_capture;
                        else if (extra == 0)
                            key.port_word = ports_capture;
                        key.transport_offset = 7'(offset);
                    end
                end
            end
            expected_keys.push_back(key);
            clear_packet();
        endfunction

        function void compare_field(string field_name, logic [31:0] expected_value,
                                    logic [31:0] actual_value);
            if (expected_value !== actual_value)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time,
                         field_name, expected_value, actual_value);
            end
        endfunction

        function void check_key(logic [M_TUSER_W-1:0] tuser, logic [M_TDATA_W-1:0] tdata);
            flow_key_t want;
            if (expected_keys.size() == 0)
            begin
                errors++;
                $display("%0t: flow key beat, expected none, actual status %0d tdata 0x%0h",
                         $time, tuser, tdata);
                return;
            end
            want = expected_keys.pop_front();
            keys_checked++;
            compare_field("status", want.status, tuser);
            compare_field("source_address", want.src_addr, tdata[31:0]);
            compare_field("destination_address", want.dst_addr, tdata[63:32]);
            compare_field("ip_protocol", want.protocol, tdata[71:64]);
            compare_field("port_word", want.port_word, tdata[103:72]);
            compare_field("transport_offset", want.transport_offset, tdata[110:104]);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    flow_key_scoreboard sb = new();
    logic [7:0]  pkt_bytes[$];
    bit          idle_on = 1'b1;
    bit          hold_off_req = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned settings_applied = 0;

    ipv4_flow_key_extractor u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser[0], s_tlast, s_tuser[1]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_key(m_tuser, m_tdata);
    end

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input bit first_flag,
                             input bit last_flag, input bit ipv4_flag);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {ipv4_flag, first_flag};
        s_tlast  <= last_flag;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_packet(input bit ipv4_flag, input bit mark_first, input bit with_last);
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], (i == 0) && mark_first,
                      (i == pkt_bytes.size() - 1) && with_last,
                      (i == 0) ? ipv4_flag : 1'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_keys.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frag_check_en(input bit value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FRAG_CHECK_EN;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(value))
        begin
            sb.errors++;
            $display("%0t: fragment check enable readback mismatch, expected 0x%0h, actual 0x%0h",
                     $time, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.frag_check_en = value;
        settings_applied++;
    endtask

    function automatic void fill_random(input int unsigned count);
        pkt_bytes.delete();
        for (int i = 0; i < count; i++)
            pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_ipv4_packet();
        logic [3:0]  ihl;
        logic [7:0]  proto;
        int unsigned needed;
        int unsigned count;
        int unsigned pick;
        ihl = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       proto = PROTO_TCP;
            1:       proto = PROTO_UDP;
            2:       proto = PROTO_DCCP;
            3:       proto = PROTO_ESP;
            4:       proto = PROTO_AH;
            5:       proto = PROTO_SCTP;
            6:       proto = PROTO_UDPLITE;
            7:       proto = PROTO_NONE;
            default: proto = 8'($urandom);
        endcase
        needed = ihl * 4 + ((proto == PROTO_AH) ? 8 : 4);
        if (needed < MIN_HEADER)
            needed = MIN_HEADER;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            count = needed + $urandom_range(0, 6);
        else if (pick < 17)
            count = needed - $urandom_range(1, 4);
        else if (pick < 19)
            count = $urandom_range(1, 19);
        else
            count = $urandom_range(100, 140);
        fill_random(count);
        pkt_bytes[0] = {pkt_bytes[0][7:4], ihl};
        if (count > 7 && $urandom_range(0, 3) != 0)
        begin
            pkt_bytes[6] = pkt_bytes[6] & 8'hC0;
            pkt_bytes[7] = 8'h00;
        end
        if (count > 9)
            pkt_bytes[9] = proto;
    endfunction

    initial
    begin
        bit          phase_done;
        bit          ended_clean;
        int unsigned phase_start;
        int unsigned pick;
        int unsigned keep;
        bit          phase_values[4];

        phase_values = '{1'b0, 1'b1, 1'b0, 1'b1};
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Non-IPv4 packet, a one-byte IPv4 packet that is too short, a packet cut
        // off by a new first byte, then an IHL of zero where the ports overlap the
        // header.
        pkt_bytes = '{8'hFF, 8'h00};
        send_packet(1'b0, 1'b1, 1'b1);
        pkt_bytes = '{8'h45};
        send_packet(1'b1, 1'b1, 1'b1);
        pkt_bytes = '{8'h45, 8'h00};
        send_packet(1'b1, 1'b1, 1'b0);
        pkt_bytes = '{8'h40, 8'h00, 8'h00, 8'h14, 8'h12, 8'h34, 8'h40, 8'h00, 8'h40, PROTO_TCP,
                      8'hAB, 8'hCD, 8'hC0, 8'hA8, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet(1'b1, 1'b1, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            set_frag_check_en(phase_values[phase]);
            idle_on = (phase != 3);
            if (phase == 1)
                hold_off_req = 1'b1;
            phase_start = bytes_sent;
            do
            begin
                pick = $urandom_range(0, 99);
                ended_clean = 1'b1;
                if (pick < 70)
                begin
                    build_ipv4_packet();
                    send_packet(1'b1, $urandom_range(0, 5) != 0, 1'b1);
                end
                else if (pick < 84)
                begin
                    fill_random($urandom_range(1, 40));
                    send_packet(1'b0, 1'b1, 1'b1);
                end
                else if (pick < 94)
                begin
                    build_ipv4_packet();
                    keep = $urandom_range(1, pkt_bytes.size());
                    while (pkt_bytes.size() > keep)
                        void'(pkt_bytes.pop_back());
                    send_packet(1'($urandom), 1'b1, 1'b0);
                    ended_clean = 1'b0;
                end
                else
                begin
                    fill_random($urandom_range(1, 30));
                    send_packet(1'b1, 1'b1, 1'b1);
                end
                phase_done = ended_clean && (bytes_sent - phase_start >= PHASE_BYTES);
            end
            while (!phase_done);
        end

        wait_drained();
        $display("Sent %0d packet bytes and checked %0d flow keys",
                 bytes_sent, sb.keys_checked);
        $display("across %0d fragment check settings, with sink stalls and a long hold-off.",
                 settings_applied);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/fkx_pkg.sv
design/fkx_front.sv
design/fkx_queue.sv
design/fkx_back.sv
design/ipv4_flow_key_extractor.sv
verif/tb_ipv4_flow_key_extractor.sv
